[sv/besa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package besa_pkg;

  // Default scratchpad size in bytes
  localparam int unsigned STORE_BYTES_DEF = 16384;

  // Byte lanes per memory row (one bank per lane)
  localparam int unsigned LANES = 8;

  // Window base after reset
  localparam logic [31:0] WINDOW_BASE_RST = 32'hE000_0000;

  // Operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Legal access sizes in bytes
  localparam logic [3:0] SIZE_1 = 4'd1;
  localparam logic [3:0] SIZE_2 = 4'd2;
  localparam logic [3:0] SIZE_4 = 4'd4;
  localparam logic [3:0] SIZE_8 = 4'd8;

  // Payload widths
  localparam int unsigned IN_DATA_W  = 104;  // 100 field bits padded to bytes
  localparam int unsigned OUT_DATA_W = 64;

endpackage

`default_nettype wire

[sv/big_endian_scratchpad_access.sv]
`timescale 1ns / 1ps
`default_nettype none

// Byte-addressed scratchpad in a bus window starting at window_base.
// Input channel (s_axis_*): one access per transaction, read or write of
//   1, 2, 4 or 8 bytes at any byte address, big-endian byte order.
// Output channel (m_axis_*): exactly one result transaction per access:
//   read data zero-extended (zero for writes and rejects) plus an accepted flag.
// Config channel (cfg_*): writes window_base; always ready, write only when idle.
// Storage: eight byte-wide banks of STORE_BYTES/8 rows, synchronous memories
//   with a registered read port. An unaligned access touches each bank at most
//   once, so all bytes of an access are read or written together.
// Result: registered, valid from the cycle after the input transaction.
// Throughput: one access per cycle while the output is not stalled; a write
//   followed at once by a read of the same bytes needs no forwarding since the
//   write lands at the same edge the read address is issued from the next cycle.
// Stall: s_axis_tready drops while a result is held and m_axis_tready is low;
//   read data stays in the bank output registers until taken.
// Reset: a clearing pass writes zero to every row in turn; no access is taken
//   during that pass, but configuration writes are.
module big_endian_scratchpad_access #(
  parameter int unsigned STORE_BYTES = besa_pkg::STORE_BYTES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // fields from bit 0 up: address[31:0], access_bytes[3:0], write_data[63:0], zero pad
  input  wire logic [besa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // fields: operation
  input  wire logic                             s_axis_tuser,
  input  wire logic                             s_axis_tvalid,
  output logic                                  s_axis_tready,
  // fields from bit 0 up: read_data[63:0]
  output logic [besa_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
  // fields: accepted
  output logic                                  m_axis_tuser,
  output logic                                  m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [31:0]                      cfg_data_i
);

  localparam int unsigned LANES = besa_pkg::LANES;
  localparam int unsigned ROWS  = (STORE_BYTES + LANES - 1) / LANES;
  localparam int unsigned OFF_W = $clog2(STORE_BYTES);
  localparam int unsigned ROW_W = OFF_W - 3;

  // Input field unpacking
  logic [31:0] address;
  logic [3:0]  access_bytes;
  logic [63:0] write_data;
  logic        operation;

  assign address      = s_axis_tdata[31:0];
  assign access_bytes = s_axis_tdata[35:32];
  assign write_data   = s_axis_tdata[99:36];
  assign operation    = s_axis_tuser;

  // Config register
  logic [31:0] window_base_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_base_q <= besa_pkg::WINDOW_BASE_RST;
    end else if (cfg_valid_i) begin
      window_base_q <= cfg_data_i;
    end
  end

  // Clearing pass after reset
  logic             clearing_q, clearing_d;
  logic [ROW_W-1:0] clr_row_q, clr_row_d;

  always_comb begin
    clearing_d = clearing_q;
    clr_row_d  = clr_row_q;
    if (clearing_q) begin
      clr_row_d = clr_row_q + ROW_W'(1);
      if (clr_row_q == ROW_W'(ROWS - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_row_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_row_q  <= clr_row_d;
    end
  end

  // Handshake
  logic out_valid_q, out_valid_d;
  logic accept;

  assign s_axis_tready = !clearing_q && (!out_valid_q || m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Range and size check
  logic        size_ok;
  logic [31:0] rel;
  logic [32:0] range_end;
  logic        in_window;
  logic        ok;

  assign size_ok = (access_bytes == besa_pkg::SIZE_1) || (access_bytes == besa_pkg::SIZE_2) ||
                   (access_bytes == besa_pkg::SIZE_4) || (access_bytes == besa_pkg::SIZE_8);
  assign rel       = address - window_base_q;
  assign range_end = {1'b0, rel} + 33'(access_bytes);
  assign in_window = (address >= window_base_q) && (range_end <= 33'(STORE_BYTES));
  assign ok        = size_ok && in_window;

  logic [OFF_W-1:0] off;
  logic [2:0]       lo;
  logic [ROW_W-1:0] row0;

  assign off  = rel[OFF_W-1:0];
  assign lo   = off[2:0];
  assign row0 = off[OFF_W-1:3];

  // Byte banks: bank b holds bytes whose offset mod 8 equals b
  logic [7:0] rdata_q [LANES];

  for (genvar b = 0; b < LANES; b++) begin : g_bank
    logic [7:0]       mem [ROWS];
    logic [2:0]       k;       // byte index within the access
    logic             active;
    logic [2:0]       sh;      // byte position within write_data
    logic [ROW_W-1:0] row;
    logic             we;
    logic             re;
    logic [ROW_W-1:0] waddr;
    logic [7:0]       wbyte;

    assign k      = 3'(b) - lo;
    assign active = ({1'b0, k} < access_bytes);
    assign sh     = 3'(access_bytes - 4'd1) - k;
    // wraps into the next row when this bank sits below the start lane
    assign row    = row0 + ROW_W'(3'(b) < lo);
    assign re     = accept && ok && active && (operation == besa_pkg::OP_READ);
    assign we     = clearing_q || (accept && ok && active && (operation == besa_pkg::OP_WRITE));
    assign waddr  = clearing_q ? clr_row_q : row;
    assign wbyte  = clearing_q ? 8'h00 : write_data[{sh, 3'b000} +: 8];

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr] <= wbyte;
      end
      if (re) begin
        rdata_q[b] <= mem[row];
      end
    end
  end

  // Result stage metadata
  logic       accepted_q;
  logic       rd_ok_q;
  logic [2:0] lo_q;
  logic [3:0] n_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      accepted_q <= ok;
      rd_ok_q    <= ok && (operation == besa_pkg::OP_READ);
      lo_q       <= lo;
      n_q        <= access_bytes;
    end
  end

  // Big-endian assembly: result byte j comes from access byte n-1-j
  logic [63:0] read_data;

  always_comb begin
    logic [2:0] bank;
    read_data = '0;
    bank      = '0;
    for (int j = 0; j < LANES; j++) begin
      bank = lo_q + 3'(n_q - 4'd1) - 3'(j);
      if (rd_ok_q && (4'(j) < n_q)) begin
        read_data[j*8 +: 8] = rdata_q[bank];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = read_data;
  assign m_axis_tuser  = accepted_q;

endmodule

`default_nettype wire

[bench/besa_access_checker.sv]
`timescale 1ns / 1ps

// Watches the access, result and config channels of the scratchpad, keeps
// its own byte store and window base, and compares every result transaction
// with the oldest predicted one.
module besa_access_checker #(
  parameter int unsigned STORE_BYTES = besa_pkg::STORE_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [besa_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tuser,
  input  logic                             s_axis_tvalid,
  input  logic                             s_axis_tready,
  input  logic [besa_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input  logic                             m_axis_tuser,
  input  logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  input  logic                             cfg_ready_i,
  input  logic [31:0]                      cfg_data_i,
  output int                               fail_count_o,
  output int                               pending_count_o
);

  typedef struct packed {
    logic [63:0] read_data;
    logic        accepted;
  } access_result_t;

  logic [7:0]     scratch_mem [STORE_BYTES];
  logic [31:0]    window_base;
  access_result_t pending_results [$];
  int             fails;

  // Applies one access to the local store and returns the result it yields.
  function automatic access_result_t run_access(input logic        op,
                                                input logic [31:0] addr,
                                                input logic [3:0]  nbytes,
                                                input logic [63:0] wdata);
    access_result_t res;
    logic [31:0]    off;
    res = '0;
    if (!(nbytes inside {besa_pkg::SIZE_1, besa_pkg::SIZE_2,
                         besa_pkg::SIZE_4, besa_pkg::SIZE_8})) return res;
    // no wrap from the top of the address space into the window
    if (addr < window_base) return res;
    off = addr - window_base;
    if (off > STORE_BYTES || nbytes > STORE_BYTES - off) return res;
    for (int i = 0; i < nbytes; i++) begin
      if (op == besa_pkg::OP_READ) begin
        res.read_data = {res.read_data[55:0], scratch_mem[off + i]};
      end else begin
        scratch_mem[off + i] = wdata[(nbytes - 1 - i) * 8 +: 8];
      end
    end
    res.accepted = 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    access_result_t want;
    if (!rst_ni) begin
      foreach (scratch_mem[i]) scratch_mem[i] = '0;
      window_base = besa_pkg::WINDOW_BASE_RST;
      pending_results.delete();
      fails = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) window_base = cfg_data_i;
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          $error("result transaction with none pending: read_data=%h accepted=%b",
                 m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          want = pending_results.pop_front();
          if (m_axis_tdata !== want.read_data) begin
            $error("read_data: expected %h, got %h", want.read_data, m_axis_tdata);
            fails++;
          end
          if (m_axis_tuser !== want.accepted) begin
            $error("accepted: expected %b, got %b", want.accepted, m_axis_tuser);
            fails++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(run_access(s_axis_tuser, s_axis_tdata[31:0],
                                             s_axis_tdata[35:32], s_axis_tdata[99:36]));
      end
    end
    fail_count_o    <= fails;
    pending_count_o <= pending_results.size();
  end

endmodule

[bench/big_endian_scratchpad_access_tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the scratchpad; prediction lives in the checker.
module big_endian_scratchpad_access_tb;

  localparam int unsigned SPAD_BYTES  = besa_pkg::STORE_BYTES_DEF;
  localparam int          NUM_PHASES  = 8;
  localparam int          PHASE_ITEMS = 205;

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  // address[31:0], access_bytes[3:0], write_data[63:0], pad
  logic [besa_pkg::IN_DATA_W-1:0]  s_axis_tdata;
  logic                            s_axis_tuser;   // operation
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [besa_pkg::OUT_DATA_W-1:0] m_axis_tdata;   // read_data[63:0]
  logic                            m_axis_tuser;   // accepted
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [31:0]                     cfg_data_i;
  int                              fail_count;
  int                              pending_count;

  int                              src_idle_pct;
  int                              dst_stall_pct;
  logic [31:0]                     window_base;   // bench copy, steers address choice

  always #4 clk_i = ~clk_i;

  big_endian_scratchpad_access DUT (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  besa_access_checker checker_i (
    .clk_i, .rst_ni,
    .s_axis_tdata, .s_axis_tuser, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tuser, .m_axis_tvalid, .m_axis_tready,
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_count_o(pending_count)
  );

  // Result side: random backpressure, one decision per cycle.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= dst_stall_pct);
  end

  // One access transaction. tvalid is only dropped while idling, so back to
  // back transactions keep it high without a same-step toggle.
  task automatic send_access(input logic        op,
                             input logic [31:0] addr,
                             input logic [3:0]  nbytes,
                             input logic [63:0] wdata);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'h0, wdata, nbytes, addr};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Hold off new accesses until every predicted result has been taken.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [31:0] base);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= base;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    window_base = base;
  endtask

  // Address mix: most traffic packed into the first and last rows of the
  // window so reads land on written bytes; the rest probes the edges or random addresses.
  function automatic logic [31:0] pick_address();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 40) return window_base + $urandom_range(0, 63);
    if (sel < 60) return window_base + SPAD_BYTES - $urandom_range(1, 72);
    if (sel < 65) return window_base + SPAD_BYTES + $urandom_range(0, 15);
    if (sel < 80) return window_base + $urandom_range(0, SPAD_BYTES - 1);
    if (sel < 90) return window_base - $urandom_range(1, 16);
    return $urandom;
  endfunction

  task automatic random_access();
    logic [3:0]  nbytes;
    logic        op;
    logic [31:0] addr;
    case ($urandom_range(0, 19))
      0, 1, 2, 3:     nbytes = besa_pkg::SIZE_1;
      4, 5, 6, 7:     nbytes = besa_pkg::SIZE_2;
      8, 9, 10, 11:   nbytes = besa_pkg::SIZE_4;
      12, 13, 14, 15: nbytes = besa_pkg::SIZE_8;
      default:        nbytes = 4'($urandom_range(0, 15));   // mostly illegal sizes
    endcase
    op   = $urandom_range(0, 1) ? besa_pkg::OP_WRITE : besa_pkg::OP_READ;
    addr = pick_address();
    send_access(op, addr, nbytes, {$urandom, $urandom});
  endtask

  initial begin : stimulus
    logic [31:0] b;
    logic [31:0] phase_base [NUM_PHASES];
    phase_base = '{32'h0000_0000, 32'hFFFF_C000, 32'hFFFF_FFFF, 32'h0,
                   besa_pkg::WINDOW_BASE_RST, 32'h8000_0000, 32'h0, 32'h0000_3FFF};
    rst_ni        = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = besa_pkg::OP_READ;
    s_axis_tvalid = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    src_idle_pct  = 0;
    dst_stall_pct = 0;
    window_base   = besa_pkg::WINDOW_BASE_RST;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // config is taken during the clearing pass; accesses wait on tready
    write_window(besa_pkg::WINDOW_BASE_RST);

    // directed: byte order, unaligned spans, window edges, bad sizes
    b = besa_pkg::WINDOW_BASE_RST;
    send_access(besa_pkg::OP_WRITE, b, besa_pkg::SIZE_8, 64'h0123_4567_89AB_CDEF);
    send_access(besa_pkg::OP_READ,  b, besa_pkg::SIZE_8, '0);
    send_access(besa_pkg::OP_READ,  b, besa_pkg::SIZE_1, '0);
    send_access(besa_pkg::OP_READ,  b + 3, besa_pkg::SIZE_2, '0);
    send_access(besa_pkg::OP_READ,  b + 5, besa_pkg::SIZE_4, '0);   // crosses a row
    send_access(besa_pkg::OP_WRITE, b + 1, besa_pkg::SIZE_2, '1);   // low two bytes only
    send_access(besa_pkg::OP_WRITE, b + 7, besa_pkg::SIZE_4, 64'hFFFF_FFFF_A5C3_3C5A);
    send_access(besa_pkg::OP_READ,  b, besa_pkg::SIZE_8, '1);
    send_access(besa_pkg::OP_READ,  b + 7, besa_pkg::SIZE_4, '0);
    send_access(besa_pkg::OP_WRITE, b + SPAD_BYTES - 8, besa_pkg::SIZE_8, '1);  // last fitting
    send_access(besa_pkg::OP_READ,  b + SPAD_BYTES - 8, besa_pkg::SIZE_8, '0);
    send_access(besa_pkg::OP_WRITE, b + SPAD_BYTES - 1, besa_pkg::SIZE_1, 64'h5A);
    send_access(besa_pkg::OP_READ,  b + SPAD_BYTES - 1, besa_pkg::SIZE_1, '0);
    send_access(besa_pkg::OP_WRITE, b + SPAD_BYTES - 7, besa_pkg::SIZE_8, '0);  // runs past end
    send_access(besa_pkg::OP_READ,  b + SPAD_BYTES - 1, besa_pkg::SIZE_2, '0);
    send_access(besa_pkg::OP_READ,  b + SPAD_BYTES, besa_pkg::SIZE_1, '0);
    send_access(besa_pkg::OP_READ,  b - 1, besa_pkg::SIZE_1, '0);              // below base
    send_access(besa_pkg::OP_WRITE, 32'h0000_0000, besa_pkg::SIZE_4, '1);
    send_access(besa_pkg::OP_READ,  32'hFFFF_FFFF, besa_pkg::SIZE_1, '0);      // no wrap
    send_access(besa_pkg::OP_WRITE, b, 4'd0, '1);
    send_access(besa_pkg::OP_WRITE, b, 4'd3, '1);
    send_access(besa_pkg::OP_WRITE, b, 4'd7, '1);
    send_access(besa_pkg::OP_WRITE, b, 4'd15, '1);
    send_access(besa_pkg::OP_READ,  b, 4'd9, '0);
    send_access(besa_pkg::OP_READ,  b, besa_pkg::SIZE_8, '0);                  // unchanged
    drain_results();

    // random phases: window moves between phases, idling cycles through
    // none / sender 83% / receiver 83% / both 28%
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 3 || ph == 6) phase_base[ph] = $urandom;
      write_window(phase_base[ph]);
      case (ph % 4)
        0:       begin src_idle_pct = 0;  dst_stall_pct = 0;  end
        1:       begin src_idle_pct = 83; dst_stall_pct = 0;  end
        2:       begin src_idle_pct = 0;  dst_stall_pct = 83; end
        default: begin src_idle_pct = 28; dst_stall_pct = 28; end
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == PHASE_ITEMS / 2) drain_results();
        random_access();
      end
      drain_results();
    end

    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
sv/besa_pkg.sv
sv/big_endian_scratchpad_access.sv
bench/besa_access_checker.sv
bench/big_endian_scratchpad_access_tb.sv
